// ----- rtl/core/fdtd1d_pkg.sv -----
// ----------------------------------------------------------------------------
// fdtd1d_pkg
// Shared widths, register indexes, reset values and the memory control
// bundle of the one-dimensional Yee cell update core.
// ----------------------------------------------------------------------------
package fdtd1d_pkg;

  localparam int MAX_CELLS_DEF   = 1024;
  localparam int FIELD_WIDTH_DEF = 32;

  localparam int GRID_LEN_W = 11;
  localparam int H_COEFF_W  = 24;
  localparam int E_COEFF_W  = 16;
  localparam int INV_EPS_W  = 16;
  localparam int SRC_W      = 32;
  localparam int K_E_W      = INV_EPS_W + E_COEFF_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_COEFF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_E_COEFF     = 2'd2;

  localparam logic [GRID_LEN_W-1:0] GRID_LENGTH_RST = 11'd200;
  localparam logic [H_COEFF_W-1:0]  H_COEFF_RST     = 24'd44502;
  localparam logic [E_COEFF_W-1:0]  E_COEFF_RST     = 16'd377;

  localparam int MIN_GRID = 2;
  localparam int H_SHIFT  = 24;
  localparam int E_SHIFT  = 14;

  typedef struct packed {
    logic rd_en;
    logic we_ez;
    logic we_hy;
  } mem_ctl_t;

endpackage

// ----- rtl/core/fdtd_1d_yee_cell_update_core.sv -----
// ----------------------------------------------------------------------------
// fdtd_1d_yee_cell_update_core
// In-place 1D Yee leapfrog update, one grid cell per input beat.
// ----------------------------------------------------------------------------
// After reset the core zeroes every address of the Ez and Hy memories and
// takes no input beat in that time; configuration writes are accepted
// throughout. Each cell then passes five clocked steps, the first at its input
// beat: one registered memory read, the Hy multiply, the Hy round and saturate,
// the Ez multiply, and the Ez round, saturate and write-back. The result is
// registered at the Ez step, which holds while an earlier result still waits
// for out_ready. One cell is in flight at a time; the next input beat is taken
// as soon as the result is in the output register, even while that result
// waits for out_ready.
// ----------------------------------------------------------------------------
module fdtd_1d_yee_cell_update_core #(
  parameter int MAX_CELLS   = fdtd1d_pkg::MAX_CELLS_DEF,
  parameter int FIELD_WIDTH = fdtd1d_pkg::FIELD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [fdtd1d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdtd1d_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [fdtd1d_pkg::INV_EPS_W-1:0]       in_inv_permittivity,
  input  logic signed [fdtd1d_pkg::SRC_W-1:0]    in_source_term,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [$clog2(MAX_CELLS)-1:0]           out_cell_index,
  output logic signed [FIELD_WIDTH-1:0]          out_ez_value,
  output logic signed [FIELD_WIDTH-1:0]          out_hy_value,
  output logic                                   out_last_cell
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int FW = FIELD_WIDTH;
  localparam int CW = (AW + 1 > fdtd1d_pkg::GRID_LEN_W) ? AW + 1 : fdtd1d_pkg::GRID_LEN_W;
  localparam int PH = FW + fdtd1d_pkg::H_COEFF_W + 2;
  localparam int HS = FW + 3;
  localparam int PE = FW + fdtd1d_pkg::K_E_W + 2;
  localparam int ES = FW + 22;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MULH  = 3'd2;
  localparam logic [2:0] S_HY    = 3'd3;
  localparam logic [2:0] S_MULE  = 3'd4;
  localparam logic [2:0] S_EZ    = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  logic [fdtd1d_pkg::GRID_LEN_W-1:0] grid_length_r;
  logic [fdtd1d_pkg::H_COEFF_W-1:0]  h_coeff_r;
  logic [fdtd1d_pkg::E_COEFF_W-1:0]  e_coeff_r;

  logic [fdtd1d_pkg::INV_EPS_W-1:0]    inv_eps_r;
  logic signed [fdtd1d_pkg::SRC_W-1:0] src_r;
  logic [AW-1:0]                       cell_r;
  logic                                last_r;
  logic [fdtd1d_pkg::K_E_W-1:0]        k_e_r;
  logic signed [PH-1:0]                prod_h_r;
  logic signed [FW-1:0]                hy_new_r;
  logic signed [FW-1:0]                prev_hy_r;
  logic signed [PE-1:0]                prod_e_r;

  logic out_valid_r;
  logic [AW-1:0] out_cell_r;
  logic signed [FW-1:0] out_ez_r, out_hy_r;
  logic out_last_r;

  logic [CW-1:0] gl_ext, n_eff;
  logic [AW-1:0] cell_pick;
  logic          last_pick;
  logic          accept, fire;

  fdtd1d_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0] mem_wr_addr;
  logic [FW-1:0] mem_wr_ez, mem_wr_hy;
  logic [FW-1:0] rd_ez_here, rd_ez_next, rd_hy;

  logic signed [FW:0]   dh, de;
  logic signed [FW-1:0] ez_next_eff;
  logic signed [PH-1:0] hy_term;
  logic signed [HS-1:0] hy_sum;
  logic signed [FW-1:0] hy_sat;
  logic signed [PE-1:0] ez_term;
  logic signed [ES-1:0] ez_sum;
  logic signed [FW-1:0] ez_sat, ez_new;

  // effective grid length and the cell this beat updates
  always_comb begin
    gl_ext = CW'(grid_length_r);
    if (gl_ext < CW'(fdtd1d_pkg::MIN_GRID)) begin
      n_eff = CW'(fdtd1d_pkg::MIN_GRID);
    end else if (gl_ext > CW'(MAX_CELLS)) begin
      n_eff = CW'(MAX_CELLS);
    end else begin
      n_eff = gl_ext;
    end
    cell_pick = (CW'(pos_r) >= n_eff) ? '0 : pos_r;
    last_pick = (CW'(cell_pick) + 1'b1 >= n_eff);
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_EZ) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pos_nxt     = pos_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAX_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MULH;
          pos_nxt   = last_pick ? '0 : cell_pick + 1'b1;
        end
      end
      S_MULH:  state_nxt = S_HY;
      S_HY:    state_nxt = S_MULE;
      S_MULE:  state_nxt = S_EZ;
      S_EZ: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      pos_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_length_r <= fdtd1d_pkg::GRID_LENGTH_RST;
      h_coeff_r     <= fdtd1d_pkg::H_COEFF_RST;
      e_coeff_r     <= fdtd1d_pkg::E_COEFF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fdtd1d_pkg::REG_GRID_LENGTH:
          grid_length_r <= cfg_wdata[fdtd1d_pkg::GRID_LEN_W-1:0];
        fdtd1d_pkg::REG_H_COEFF:
          h_coeff_r     <= cfg_wdata[fdtd1d_pkg::H_COEFF_W-1:0];
        fdtd1d_pkg::REG_E_COEFF:
          e_coeff_r     <= cfg_wdata[fdtd1d_pkg::E_COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // memory access: clear sweep, read on accept, write back on completion
  always_comb begin
    mem_ctl.rd_en = accept;
    mem_ctl.we_hy = (state_r == S_CLEAR) || fire;
    mem_ctl.we_ez = (state_r == S_CLEAR) || (fire && (cell_r != '0));
    if (state_r == S_CLEAR) begin
      mem_wr_addr = clr_cnt_r;
      mem_wr_ez   = '0;
      mem_wr_hy   = '0;
    end else begin
      mem_wr_addr = cell_r;
      mem_wr_ez   = ez_new;
      mem_wr_hy   = hy_new_r;
    end
  end

  fdtd1d_field_mem #(
    .DEPTH (MAX_CELLS),
    .AW    (AW),
    .FW    (FW)
  ) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .rd_addr    (cell_pick),
    .wr_addr    (mem_wr_addr),
    .wr_ez      (mem_wr_ez),
    .wr_hy      (mem_wr_hy),
    .rd_ez_here (rd_ez_here),
    .rd_ez_next (rd_ez_next),
    .rd_hy      (rd_hy)
  );

  // arithmetic
  always_comb begin
    ez_next_eff = last_r ? '0 : $signed(rd_ez_next);
    dh = (FW+1)'(ez_next_eff) - (FW+1)'($signed(rd_ez_here));

    hy_term = (prod_h_r + PH'(2 ** (fdtd1d_pkg::H_SHIFT - 1))) >>> fdtd1d_pkg::H_SHIFT;
    hy_sum  = HS'($signed(rd_hy)) + HS'(hy_term);
    if (&hy_sum[HS-1:FW-1] || ~|hy_sum[HS-1:FW-1]) begin
      hy_sat = hy_sum[FW-1:0];
    end else begin
      hy_sat = {hy_sum[HS-1], {(FW-1){~hy_sum[HS-1]}}};
    end

    de = (FW+1)'(hy_new_r) - (FW+1)'(prev_hy_r);

    ez_term = (prod_e_r + PE'(2 ** (fdtd1d_pkg::E_SHIFT - 1))) >>> fdtd1d_pkg::E_SHIFT;
    ez_sum  = ES'($signed(rd_ez_here)) + ES'(ez_term) + ES'(src_r);
    if (&ez_sum[ES-1:FW-1] || ~|ez_sum[ES-1:FW-1]) begin
      ez_sat = ez_sum[FW-1:0];
    end else begin
      ez_sat = {ez_sum[ES-1], {(FW-1){~ez_sum[ES-1]}}};
    end
    ez_new = (cell_r == '0) ? $signed(rd_ez_here) : ez_sat;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inv_eps_r <= in_inv_permittivity;
      src_r     <= in_source_term;
      cell_r    <= cell_pick;
      last_r    <= last_pick;
    end
    if (state_r == S_MULH) begin
      prod_h_r <= PH'(dh) * PH'($signed({1'b0, h_coeff_r}));
      k_e_r    <= fdtd1d_pkg::K_E_W'(inv_eps_r) * fdtd1d_pkg::K_E_W'(e_coeff_r);
    end
    if (state_r == S_HY) begin
      hy_new_r <= hy_sat;
    end
    if (state_r == S_MULE) begin
      prod_e_r <= PE'(de) * PE'($signed({1'b0, k_e_r}));
    end
    if (fire) begin
      out_cell_r <= cell_r;
      out_ez_r   <= ez_new;
      out_hy_r   <= hy_new_r;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hy_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        prev_hy_r <= hy_new_r;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_cell_r;
  assign out_ez_value   = out_ez_r;
  assign out_hy_value   = out_hy_r;
  assign out_last_cell  = out_last_r;

endmodule

// ----- rtl/core/fdtd1d_field_mem.sv -----
// ----------------------------------------------------------------------------
// fdtd1d_field_mem
// Ez and Hy field memories. Ez has two registered read ports (cell and next
// cell), Hy one; both share one write address.
// ----------------------------------------------------------------------------
module fdtd1d_field_mem #(
  parameter int DEPTH = fdtd1d_pkg::MAX_CELLS_DEF,
  parameter int AW    = $clog2(fdtd1d_pkg::MAX_CELLS_DEF),
  parameter int FW    = fdtd1d_pkg::FIELD_WIDTH_DEF
) (
  input  logic                 clk,
  input  fdtd1d_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [FW-1:0]        wr_ez,
  input  logic [FW-1:0]        wr_hy,
  output logic [FW-1:0]        rd_ez_here,
  output logic [FW-1:0]        rd_ez_next,
  output logic [FW-1:0]        rd_hy
);

  logic [FW-1:0] ez_mem [DEPTH];
  logic [FW-1:0] hy_mem [DEPTH];
  logic [AW-1:0] rd_addr_next;

  // next cell wraps at the top; its data is discarded there anyway
  assign rd_addr_next = (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.we_ez) begin
      ez_mem[wr_addr] <= wr_ez;
    end
    if (ctl.rd_en) begin
      rd_ez_here <= ez_mem[rd_addr];
      rd_ez_next <= ez_mem[rd_addr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we_hy) begin
      hy_mem[wr_addr] <= wr_hy;
    end
    if (ctl.rd_en) begin
      rd_hy <= hy_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/fdtd1d_checker.sv -----
// ----------------------------------------------------------------------------
// fdtd1d_checker
// Port-level checks of the result channel, bound to the update core.
// ----------------------------------------------------------------------------
module fdtd1d_checker #(
  parameter int AW = $clog2(fdtd1d_pkg::MAX_CELLS_DEF),
  parameter int FW = fdtd1d_pkg::FIELD_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [AW-1:0]        out_cell_index,
  input logic signed [FW-1:0] out_ez_value,
  input logic signed [FW-1:0] out_hy_value,
  input logic                 out_last_cell
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cell_index) && $stable(out_ez_value)
      && $stable(out_hy_value) && $stable(out_last_cell))
    else $error("stalled result beat changed");

  // Ez of cell 0 is held at its cleared value
  a_cell0_ez: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cell_index == '0) |-> (out_ez_value == '0))
    else $error("Ez of cell 0 moved");

  // a sweep always spans at least two cells
  a_last_not0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_cell |-> (out_cell_index != '0))
    else $error("sweep ended on cell 0");

endmodule

bind fdtd_1d_yee_cell_update_core fdtd1d_checker #(
  .AW (AW),
  .FW (FIELD_WIDTH)
) u_fdtd1d_checker (.*);

// ----- verif/fdtd_1d_yee_cell_update_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdtd_1d_yee_cell_update_core_tb
// Streams grid cells into the Yee update core and checks every result beat
// against its directed row or an in-bench leapfrog predictor that keeps its
// own Ez/Hy grid. A short table of directed cells and register writes comes
// first. Random sweeps under several grid and coefficient settings follow,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module fdtd_1d_yee_cell_update_core_tb;

  localparam int CELL_IDX_W       = $clog2(fdtd1d_pkg::MAX_CELLS_DEF);
  localparam int FW               = fdtd1d_pkg::FIELD_WIDTH_DEF;
  localparam int NUM_PHASES       = 8;
  localparam int CELLS_PER_PHASE  = 128;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD        = 200;
  localparam int TIMEOUT_NS       = 2_000_000;
  localparam logic [fdtd1d_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [127:0] FIELD_HI = (128'sd1 <<< (FW - 1)) - 128'sd1;
  localparam logic signed [127:0] FIELD_LO = -FIELD_HI - 128'sd1;

  typedef struct {
    logic [CELL_IDX_W-1:0] cell_index;
    logic signed [FW-1:0]  ez_value;
    logic signed [FW-1:0]  hy_value;
    logic                  last_cell;
  } cell_result_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                                 kind;
    logic [fdtd1d_pkg::CFG_IDX_W-1:0]          reg_idx;
    logic [fdtd1d_pkg::CFG_DATA_W-1:0]         reg_value;
    logic [fdtd1d_pkg::INV_EPS_W-1:0]          inv_eps;
    logic signed [fdtd1d_pkg::SRC_W-1:0]       source;
    bit                                        typed;
    cell_result_t                              want;
  } stim_row_t;

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   cfg_wr_en = 1'b0;
  logic [fdtd1d_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [fdtd1d_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [fdtd1d_pkg::INV_EPS_W-1:0]       in_inv_permittivity = '0;
  logic signed [fdtd1d_pkg::SRC_W-1:0]    in_source_term = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [CELL_IDX_W-1:0]                  out_cell_index;
  logic signed [FW-1:0]                   out_ez_value;
  logic signed [FW-1:0]                   out_hy_value;
  logic                                   out_last_cell;

  // predictor copy of the grid and registers
  logic [fdtd1d_pkg::GRID_LEN_W-1:0] grid_len_cfg = fdtd1d_pkg::GRID_LENGTH_RST;
  logic [fdtd1d_pkg::H_COEFF_W-1:0]  h_coeff_cfg  = fdtd1d_pkg::H_COEFF_RST;
  logic [fdtd1d_pkg::E_COEFF_W-1:0]  e_coeff_cfg  = fdtd1d_pkg::E_COEFF_RST;
  logic signed [FW-1:0]   ez_field [fdtd1d_pkg::MAX_CELLS_DEF];
  logic signed [FW-1:0]   hy_field [fdtd1d_pkg::MAX_CELLS_DEF];
  logic signed [FW-1:0]   prev_hy = '0;
  int                     sweep_pos = 0;

  cell_result_t cell_updates_due[$];
  stim_row_t    directed_rows[$];

  int  feed_gap_max = 4;
  int  drain_gap_max = 4;
  bit  hold_off_due = 1'b0;
  int  mismatch_count = 0;
  int  cells_sent = 0;
  int  cells_seen = 0;
  int  sweeps_done = 0;
  int  rail_hits = 0;
  int  reg_writes = 0;

  fdtd_1d_yee_cell_update_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_inv_permittivity (in_inv_permittivity),
    .in_source_term      (in_source_term),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cell_index      (out_cell_index),
    .out_ez_value        (out_ez_value),
    .out_hy_value        (out_hy_value),
    .out_last_cell       (out_last_cell)
  );

  always #5 clk = ~clk;

  function automatic logic signed [FW-1:0] clamp_field(logic signed [127:0] v);
    if (v > FIELD_HI) return FIELD_HI[FW-1:0];
    if (v < FIELD_LO) return FIELD_LO[FW-1:0];
    return v[FW-1:0];
  endfunction

  function automatic cell_result_t update_cell(
      logic [fdtd1d_pkg::INV_EPS_W-1:0] inv_eps,
      logic signed [fdtd1d_pkg::SRC_W-1:0] src);
    cell_result_t r;
    int n;
    int p;
    logic signed [127:0] diff, k, kb, term, acc;
    logic signed [FW-1:0] ez_here, ez_next, hy_new;
    n = grid_len_cfg;
    if (n < fdtd1d_pkg::MIN_GRID) n = fdtd1d_pkg::MIN_GRID;
    if (n > fdtd1d_pkg::MAX_CELLS_DEF) n = fdtd1d_pkg::MAX_CELLS_DEF;
    if (sweep_pos >= n) sweep_pos = 0;
    p = sweep_pos;
    ez_here = ez_field[p];
    ez_next = (p + 1 < n) ? ez_field[p + 1] : '0;
    diff = ez_next;
    diff = diff - ez_here;
    k = h_coeff_cfg;
    term = (diff * k + (128'sd1 <<< (fdtd1d_pkg::H_SHIFT - 1))) >>> fdtd1d_pkg::H_SHIFT;
    acc = hy_field[p];
    acc = acc + term;
    hy_new = clamp_field(acc);
    hy_field[p] = hy_new;
    if (p == 0) begin
      r.ez_value = ez_here;
    end else begin
      diff = hy_new;
      diff = diff - prev_hy;
      k = inv_eps;
      kb = e_coeff_cfg;
      k = k * kb;
      term = (diff * k + (128'sd1 <<< (fdtd1d_pkg::E_SHIFT - 1))) >>> fdtd1d_pkg::E_SHIFT;
      acc = ez_here;
      acc = acc + term + src;
      r.ez_value = clamp_field(acc);
      ez_field[p] = r.ez_value;
    end
    prev_hy = hy_new;
    r.cell_index = CELL_IDX_W'(p);
    r.hy_value = hy_new;
    r.last_cell = (p + 1 >= n);
    sweep_pos = r.last_cell ? 0 : p + 1;
    return r;
  endfunction

  function automatic stim_row_t beat_row(logic [fdtd1d_pkg::INV_EPS_W-1:0] inv_eps,
                                         logic [fdtd1d_pkg::SRC_W-1:0] src);
    stim_row_t r;
    r.kind = ROW_BEAT;
    r.reg_idx = '0;
    r.reg_value = '0;
    r.inv_eps = inv_eps;
    r.source = src;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [fdtd1d_pkg::INV_EPS_W-1:0] inv_eps,
                                            logic [fdtd1d_pkg::SRC_W-1:0] src, int idx,
                                            logic [FW-1:0] ez, logic [FW-1:0] hy,
                                            bit last);
    stim_row_t r;
    r = beat_row(inv_eps, src);
    r.typed = 1'b1;
    r.want.cell_index = CELL_IDX_W'(idx);
    r.want.ez_value = ez;
    r.want.hy_value = hy;
    r.want.last_cell = last;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [fdtd1d_pkg::CFG_IDX_W-1:0] idx,
                                        logic [fdtd1d_pkg::CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = beat_row('0, '0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_value = value;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [FW-1:0] want, logic [FW-1:0] got);
    mismatch_count++;
    $display("%0t ns: cell %0d %s mismatch: expected %h, got %h",
             $time, out_cell_index, what, want, got);
  endtask

  task automatic write_reg(logic [fdtd1d_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdtd1d_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      fdtd1d_pkg::REG_GRID_LENGTH: grid_len_cfg = value[fdtd1d_pkg::GRID_LEN_W-1:0];
      fdtd1d_pkg::REG_H_COEFF:     h_coeff_cfg = value[fdtd1d_pkg::H_COEFF_W-1:0];
      fdtd1d_pkg::REG_E_COEFF:     e_coeff_cfg = value[fdtd1d_pkg::E_COEFF_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_cell(logic [fdtd1d_pkg::INV_EPS_W-1:0] inv_eps,
                           logic signed [fdtd1d_pkg::SRC_W-1:0] src,
                           bit typed, cell_result_t want);
    cell_result_t predicted;
    int gap;
    gap = $urandom_range(0, feed_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_inv_permittivity <= inv_eps;
    in_source_term <= src;
    do @(posedge clk); while (!in_ready);
    predicted = update_cell(inv_eps, src);
    cell_updates_due.push_back(typed ? want : predicted);
    cells_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cell_updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin
    int wait_cycles;
    cell_result_t want;
    @(posedge clk);
    forever begin
      wait_cycles = $urandom_range(0, drain_gap_max);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        wait_cycles = LONG_HOLD;
      end
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      cells_seen++;
      if (out_last_cell) sweeps_done++;
      if (out_ez_value == FIELD_HI[FW-1:0] || out_ez_value == FIELD_LO[FW-1:0] ||
          out_hy_value == FIELD_HI[FW-1:0] || out_hy_value == FIELD_LO[FW-1:0])
        rail_hits++;
      if (cell_updates_due.size() == 0) begin
        report_mismatch("unexpected beat", '0, out_ez_value);
      end else begin
        want = cell_updates_due.pop_front();
        if (out_cell_index !== want.cell_index)
          report_mismatch("cell_index", FW'(want.cell_index), FW'(out_cell_index));
        if (out_ez_value !== want.ez_value)
          report_mismatch("ez_value", want.ez_value, out_ez_value);
        if (out_hy_value !== want.hy_value)
          report_mismatch("hy_value", want.hy_value, out_hy_value);
        if (out_last_cell !== want.last_cell)
          report_mismatch("last_cell", FW'(want.last_cell), FW'(out_last_cell));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", cell_updates_due.size());
    $display("FAIL fdtd_1d_yee_cell_update_core");
    $finish;
  end

  initial begin
    logic [fdtd1d_pkg::CFG_DATA_W-1:0]   grid_val, h_val, e_val;
    logic [fdtd1d_pkg::INV_EPS_W-1:0]    inv_eps;
    logic signed [fdtd1d_pkg::SRC_W-1:0] src;
    logic [31:0]                         rnd;
    cell_result_t                        none;
    int                                  directed_cells;

    foreach (ez_field[i]) begin
      ez_field[i] = '0;
      hy_field[i] = '0;
    end
    none.cell_index = '0;
    none.ez_value = '0;
    none.hy_value = '0;
    none.last_cell = 1'b0;

    // first sweep after clear: every Hy stays zero and Ez takes the source, save at cell 0
    directed_rows = '{
      checked_row(16'hFFFF, 32'h7FFFFFFF, 0, 32'h00000000, 32'h0, 1'b0),
      checked_row(16'h0000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h0, 1'b0),
      checked_row(16'hFFFF, 32'h80000000, 2, 32'h80000000, 32'h0, 1'b0),
      checked_row(16'h4000, 32'hFFFFFFFF, 3, 32'hFFFFFFFF, 32'h0, 1'b0),
      checked_row(16'h0001, 32'h00000001, 4, 32'h00000001, 32'h0, 1'b0),
      checked_row(16'hAAAA, 32'h55555555, 5, 32'h55555555, 32'h0, 1'b0),
      checked_row(16'h5555, 32'hAAAAAAAA, 6, 32'hAAAAAAAA, 32'h0, 1'b0),
      reg_row(fdtd1d_pkg::REG_GRID_LENGTH, 24'd0),
      beat_row(16'h4000, 32'h00000000),
      beat_row(16'hFFFF, 32'h7FFFFFFF),
      beat_row(16'h0001, 32'h80000000),
      reg_row(fdtd1d_pkg::REG_GRID_LENGTH, 24'd1),
      beat_row(16'h4000, 32'h00000000),
      beat_row(16'h4000, 32'h00012345),
      reg_row(fdtd1d_pkg::REG_H_COEFF, 24'hFFFFFF),
      reg_row(fdtd1d_pkg::REG_E_COEFF, 24'h00FFFF),
      reg_row(fdtd1d_pkg::REG_GRID_LENGTH, 24'd3),
      beat_row(16'hFFFF, 32'h00000000),
      beat_row(16'hFFFF, 32'h7FFFFFFF),
      beat_row(16'h0000, 32'h80000000),
      beat_row(16'h4000, 32'h00000001),
      beat_row(16'hFFFF, 32'hFFFF0000),
      beat_row(16'h8000, 32'h00000000),
      reg_row(REG_SPARE, 24'hFFFFFF),
      beat_row(16'h4000, 32'h00000000),
      beat_row(16'h4000, 32'h00000000),
      reg_row(fdtd1d_pkg::REG_H_COEFF, 24'h000000),
      reg_row(fdtd1d_pkg::REG_E_COEFF, 24'h000000),
      beat_row(16'hFFFF, 32'h00010000),
      beat_row(16'hFFFF, 32'hFFFF0000),
      reg_row(fdtd1d_pkg::REG_GRID_LENGTH, 24'hFFFFFF),
      beat_row(16'h4000, 32'h00000000),
      beat_row(16'h4000, 32'h00000000)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_cell(directed_rows[i].inv_eps, directed_rows[i].source,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end
    directed_cells = cells_sent;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      grid_val = 24'($urandom_range(fdtd1d_pkg::MIN_GRID, 64));
      h_val = 24'($urandom());
      e_val = 24'($urandom());
      feed_gap_max = $urandom_range(0, 1) * 16;
      drain_gap_max = $urandom_range(0, 1) * 16;
      case (ph)
        0: begin
          grid_val = 24'd8;
          h_val = fdtd1d_pkg::H_COEFF_RST;
          e_val = 24'(fdtd1d_pkg::E_COEFF_RST);
          feed_gap_max = 0;
          drain_gap_max = 0;
        end
        1: begin
          grid_val = 24'(fdtd1d_pkg::MIN_GRID);
          h_val = 24'hFFFFFF;
          e_val = 24'h00FFFF;
          feed_gap_max = 16;
          drain_gap_max = 16;
        end
        2: begin
          grid_val = 24'(fdtd1d_pkg::MAX_CELLS_DEF);
          feed_gap_max = 0;
          drain_gap_max = 16;
          hold_off_due = 1'b1;
        end
        3: begin
          grid_val = 24'($urandom_range(3, 40));
          h_val = '0;
          e_val = '0;
        end
        4: begin
          grid_val = 24'($urandom());
          grid_val[fdtd1d_pkg::GRID_LEN_W-1:0] = '1;
          h_val = fdtd1d_pkg::H_COEFF_RST;
          e_val = 24'(fdtd1d_pkg::E_COEFF_RST);
          feed_gap_max = 16;
          drain_gap_max = 0;
        end
        default: ;
      endcase
      write_reg(fdtd1d_pkg::REG_GRID_LENGTH, grid_val);
      write_reg(fdtd1d_pkg::REG_H_COEFF, h_val);
      write_reg(fdtd1d_pkg::REG_E_COEFF, e_val);

      for (int c = 0; c < CELLS_PER_PHASE; c++) begin
        case ($urandom_range(0, 7))
          0:       inv_eps = '0;
          1:       inv_eps = '1;
          2, 3:    inv_eps = 16'h4000;
          default: inv_eps = 16'($urandom());
        endcase
        rnd = $urandom();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: src = '0;
          4, 5, 6:    src = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
          7, 8:       src = 32'($signed(rnd[23:0]));
          default:    src = rnd;
        endcase
        send_cell(inv_eps, src, 1'b0, none);
      end
    end

    wait_idle();
    $display("Covered %0d cells (%0d directed), %0d finished sweeps, %0d register writes",
             cells_seen, directed_cells, sweeps_done, reg_writes);
    $display("%0d result beats carried a field pinned at a saturation limit", rail_hits);
    if (mismatch_count == 0) begin
      $display("PASS fdtd_1d_yee_cell_update_core");
    end else begin
      $display("FAIL fdtd_1d_yee_cell_update_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fdtd1d_pkg.sv
rtl/core/fdtd1d_field_mem.sv
rtl/core/fdtd_1d_yee_cell_update_core.sv
rtl/core/fdtd1d_checker.sv
verif/fdtd_1d_yee_cell_update_core_tb.sv
